// ===== hdl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, constants and helper functions shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int CntW    = 10;            // tick counter width
  localparam int RegW    = 10;            // timing register width
  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;
  localparam int PAddrW  = 5;
  localparam int PDataW  = 32;
  localparam int QDepth  = 2;             // front to back queue, power of two
  localparam int QAw     = $clog2(QDepth);
  localparam int SpanW   = CntW + RegW;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_SAMPLE,
    PH_RST_HIGH,
    PH_RST_RECOVER,
    PH_GAP,
    PH_WR_LOW,
    PH_WR_REST,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REST
  } phase_e;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    IT_TICK,
    IT_START,
    IT_SKIP
  } item_kind_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_RST_LOW   = 3'd0,
    REG_PRES_WAIT = 3'd1,
    REG_RST_REC   = 3'd2,
    REG_SLOT_GAP  = 3'd3,
    REG_WR_LOW    = 3'd4,
    REG_SLOT_REST = 3'd5,
    REG_RD_LOW    = 3'd6,
    REG_RD_SAMPLE = 3'd7
  } reg_idx_e;

  typedef logic [NumRegs-1:0][RegW-1:0] cfg_regs_t;

  typedef struct packed {
    item_kind_e  kind;
    cmd_e        cmd;
    logic [7:0]  data;
    logic        line;
  } item_t;

  localparam cfg_regs_t RegReset = {
    10'd2, 10'd2, 10'd90, 10'd10, 10'd2, 10'd420, 10'd60, 10'd500
  };

  // register value as a tick count: optional floor of one, saturated to the counter
  function automatic logic [CntW-1:0] span(input logic [RegW-1:0] v, input logic at_least_one);
    logic [SpanW-1:0] w;
    logic [SpanW-1:0] cmax;
    cmax = {{RegW{1'b0}}, {CntW{1'b1}}};
    w    = {{CntW{1'b0}}, v};
    if (at_least_one && (v == '0)) w = SpanW'(1);
    if (w > cmax) w = cmax;
    return w[CntW-1:0];
  endfunction

  function automatic logic drive_of(input phase_e ph, input logic bit0);
    logic d;
    case (ph)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: d = 1'b1;
      PH_WR_REST:                       d = ~bit0;
      default:                          d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front
// Takes input words and sorts them into ticks, starts and ignored commands.
// ----------------------------------------------------------------------------
module owbm_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        write_data_i,
  input  logic              line_in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output owbm_pkg::item_t   item_o
);
  import owbm_pkg::*;

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    item_o.cmd  = cmd_e'(command_i);
    item_o.data = write_data_i;
    item_o.line = line_in_i;
    if (!kind_i) begin
      item_o.kind = IT_TICK;
    end else if (command_i inside {CMD_RESET, CMD_WRITE, CMD_READ}) begin
      item_o.kind = IT_START;
    end else begin
      // unknown code still answers, but changes nothing
      item_o.kind = IT_SKIP;
    end
  end

endmodule

// ===== hdl/owbm_fifo.sv =====
// ----------------------------------------------------------------------------
// owbm_fifo
// Short queue of classified words between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module owbm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  owbm_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output owbm_pkg::item_t   item_o,
  output logic              valid_o
);
  import owbm_pkg::*;

  item_t            mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     count_q, count_d;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QAw+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/owbm_back.sv =====
// ----------------------------------------------------------------------------
// owbm_back
// Bus sequencer: steps reset, write and read slots one word per cycle, held while
// the output register is stalled, and registers the answer for the output channel.
// ----------------------------------------------------------------------------
module owbm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  owbm_pkg::item_t      item_i,
  output logic                 item_pop_o,
  input  owbm_pkg::cfg_regs_t  cfg_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 pull_low_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic [7:0]           read_data_o,
  output logic                 presence_o
);
  import owbm_pkg::*;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] tick_q, tick_d;
  logic [2:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  cmd_e            active_q, active_d;
  logic            pres_q, pres_d;
  logic [7:0]      last_q, last_d;
  logic            out_valid_q;

  logic            pop, tick_go, start_go;
  logic [CntW-1:0] cur_len, tick_inc, tick_nx;
  logic            reached, slot_last, gap_zero, rec_zero, rd_wait_zero;
  phase_e          slot_phase, start_phase;
  logic [7:0]      rd_shift, wr_shift;
  logic            drive, done;

  assign pop        = item_valid_i & (~out_valid_q | out_ready_i);
  assign item_pop_o = pop;
  assign tick_go    = pop & (item_i.kind == IT_TICK);
  assign start_go   = pop & (item_i.kind == IT_START) & (phase_q == PH_IDLE);

  assign gap_zero     = (span(cfg_i[REG_SLOT_GAP], 1'b0) == '0);
  assign rec_zero     = (span(cfg_i[REG_RST_REC], 1'b0) == '0);
  assign rd_wait_zero = (span(cfg_i[REG_RD_SAMPLE], 1'b0) == '0);
  assign slot_last    = (bit_q == 3'd7);
  assign slot_phase   = (active_q == CMD_WRITE) ? PH_WR_LOW : PH_RD_LOW;
  assign start_phase  = (item_i.cmd == CMD_WRITE) ? PH_WR_LOW : PH_RD_LOW;
  // read bit is taken on the first rest tick
  assign rd_shift     = (tick_q == '0) ? {item_i.line, shift_q[7:1]} : shift_q;
  assign wr_shift     = {1'b0, shift_q[7:1]};

  // length of the stretch the current phase counts
  always_comb begin
    case (phase_q)
      PH_RST_LOW:            cur_len = span(cfg_i[REG_RST_LOW], 1'b1);
      PH_RST_WAIT:           cur_len = span(cfg_i[REG_PRES_WAIT], 1'b1);
      PH_RST_RECOVER:        cur_len = span(cfg_i[REG_RST_REC], 1'b0);
      PH_GAP:                cur_len = span(cfg_i[REG_SLOT_GAP], 1'b0);
      PH_WR_LOW:             cur_len = span(cfg_i[REG_WR_LOW], 1'b1);
      PH_WR_REST, PH_RD_REST: cur_len = span(cfg_i[REG_SLOT_REST], 1'b1);
      PH_RD_LOW:             cur_len = span(cfg_i[REG_RD_LOW], 1'b1);
      PH_RD_WAIT:            cur_len = span(cfg_i[REG_RD_SAMPLE], 1'b0);
      default:               cur_len = '0;
    endcase
  end

  assign tick_inc = tick_q + CntW'(1);
  assign reached  = (tick_inc >= cur_len);
  assign tick_nx  = reached ? '0 : tick_inc;

  // next state
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    active_d = active_q;
    pres_d   = pres_q;
    last_d   = last_q;
    if (start_go) begin
      active_d = item_i.cmd;
      tick_d   = '0;
      bit_d    = '0;
      if (item_i.cmd == CMD_RESET) begin
        phase_d = PH_RST_LOW;
      end else begin
        shift_d = (item_i.cmd == CMD_WRITE) ? item_i.data : 8'h00;
        phase_d = gap_zero ? start_phase : PH_GAP;
      end
    end else if (tick_go) begin
      case (phase_q)
        PH_RST_LOW: begin
          tick_d = tick_nx;
          if (reached) phase_d = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          tick_d = tick_nx;
          if (reached) phase_d = PH_RST_SAMPLE;
        end
        PH_RST_SAMPLE: begin
          tick_d  = '0;
          pres_d  = ~item_i.line;
          phase_d = item_i.line ? PH_IDLE : PH_RST_HIGH;
        end
        PH_RST_HIGH: begin
          if (item_i.line) begin
            tick_d  = '0;
            phase_d = rec_zero ? PH_IDLE : PH_RST_RECOVER;
          end
        end
        PH_RST_RECOVER: begin
          tick_d = tick_nx;
          if (reached) phase_d = PH_IDLE;
        end
        PH_GAP: begin
          tick_d = tick_nx;
          if (reached) phase_d = slot_phase;
        end
        PH_WR_LOW: begin
          tick_d = tick_nx;
          if (reached) phase_d = PH_WR_REST;
        end
        PH_WR_REST: begin
          tick_d = tick_nx;
          if (reached) begin
            shift_d = wr_shift;
            tick_d  = '0;
            if (slot_last) begin
              phase_d = PH_IDLE;
              bit_d   = '0;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = gap_zero ? slot_phase : PH_GAP;
            end
          end
        end
        PH_RD_LOW: begin
          tick_d = tick_nx;
          if (reached) phase_d = rd_wait_zero ? PH_RD_REST : PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          tick_d = tick_nx;
          if (reached) phase_d = PH_RD_REST;
        end
        PH_RD_REST: begin
          shift_d = rd_shift;
          tick_d  = tick_nx;
          if (reached) begin
            tick_d = '0;
            if (slot_last) begin
              if (active_q == CMD_READ) last_d = rd_shift;
              phase_d = PH_IDLE;
              bit_d   = '0;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = gap_zero ? slot_phase : PH_GAP;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end
  end

  // outputs of the current word
  always_comb begin
    drive = start_go ? drive_of(phase_d, shift_d[0]) : drive_of(phase_q, shift_q[0]);
    done  = 1'b0;
    if (tick_go) begin
      case (phase_q)
        PH_RST_SAMPLE:          done = item_i.line;
        PH_RST_HIGH:            done = item_i.line & rec_zero;
        PH_RST_RECOVER:         done = reached;
        PH_WR_REST, PH_RD_REST: done = reached & slot_last;
        default:                done = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      active_q    <= CMD_RESET;
      pres_q      <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q  <= phase_d;
        tick_q   <= tick_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        active_q <= active_d;
        pres_q   <= pres_d;
        last_q   <= last_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pull_low_o  <= drive;
      busy_res_o  <= (phase_d != PH_IDLE);
      done_res_o  <= done;
      read_data_o <= last_d;
      presence_o  <= pres_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/onewire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// onewire_bus_master_unit
// 1-Wire bus master stepped by microsecond tick words, with timing registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o| kind, command, write_data, line_in
//  out     | output    | out_valid_o/out_ready_i| pull_low, busy_res, done_res,
//          |           |                        | read_data, presence
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata (apb)
//
//  one word per cycle sustained while the output is not stalled; a result word
//  is presented after its input word passes the queue entry and then the
//  sequencer output register
//  the sequencer step is one counter add and compare per word
//  reset clears the sequencer to idle, the queue to empty, timing regs to defaults
//  a stalled output holds its word; the two-entry queue keeps the input side
//  taking words until it fills
// ----------------------------------------------------------------------------
module onewire_bus_master_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    write_data_i,
  input  logic                          line_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pull_low_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [7:0]                    read_data_o,
  output logic                          presence_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owbm_pkg::PAddrW-1:0]   paddr,
  input  logic [owbm_pkg::PDataW-1:0]   pwdata,
  output logic [owbm_pkg::PDataW-1:0]   prdata,
  output logic                          pready
);
  import owbm_pkg::*;

  cfg_regs_t            cfg_q;
  logic                 cfg_wr;
  logic [RegIdxW-1:0]   cfg_idx;

  logic                 q_full, push, pop, item_valid;
  item_t                item_in, item_out;

  // register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PAddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = {{(PDataW-RegW){1'b0}}, cfg_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= RegReset;
    end else if (cfg_wr) begin
      cfg_q[cfg_idx] <= pwdata[RegW-1:0];
    end
  end

  owbm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .line_in_i    (line_in_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (item_in)
  );

  owbm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (item_out),
    .valid_o (item_valid)
  );

  owbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item_out),
    .item_pop_o   (pop),
    .cfg_i        (cfg_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pull_low_o   (pull_low_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o),
    .presence_o   (presence_o)
  );

  // a finishing word never reports the master as still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done word reported busy");

  // the bus is only pulled low during or at the end of an operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pull_low_o |-> busy_res_o || done_res_o)
    else $error("bus pulled low while idle");

  // input side only stalls when the queue holds words for the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid)
    else $error("input stalled with empty queue");

endmodule

// ===== bench/owbm_bus_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// owbm_bus_checker
// Watches the tick/command channel, the result channel and the register port
// of the 1-Wire bus master. It keeps its own copy of the bus sequencer and the
// timing registers, predicts one result word per accepted word, and compares
// every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module owbm_bus_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        kind_i,
  input  logic [1:0]                  command_i,
  input  logic [7:0]                  write_data_i,
  input  logic                        line_in_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        pull_low_i,
  input  logic                        busy_res_i,
  input  logic                        done_res_i,
  input  logic [7:0]                  read_data_i,
  input  logic                        presence_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owbm_pkg::PAddrW-1:0] paddr,
  input  logic [owbm_pkg::PDataW-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatch_total_o,
  output int                          answers_owed_o
);
  import owbm_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic       pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       present;
  } bus_answer_t;

  phase_e          seq_phase;
  logic [CntW-1:0] seq_ticks;
  logic [2:0]      seq_bit;
  logic [7:0]      seq_shift;
  cmd_e            seq_cmd;
  logic            seq_present;
  logic [7:0]      seq_last_read;
  logic [RegW-1:0] timing [NumRegs];

  bus_answer_t bus_answers_q [$];
  bus_answer_t want;
  bus_answer_t seen;
  int          mismatches;

  function automatic logic [CntW-1:0] ticks_of(input reg_idx_e idx, input logic floor_one);
    int unsigned v;
    v = timing[idx];
    if (floor_one && v == 0) v = 1;
    if (v > (2 ** CntW) - 1) v = (2 ** CntW) - 1;
    return v[CntW-1:0];
  endfunction

  // bump the slot counter, wrap to zero when the span is reached
  function automatic logic count_hit(input logic [CntW-1:0] len);
    seq_ticks = seq_ticks + 1'b1;
    if (seq_ticks >= len) begin
      seq_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic pulls_low();
    case (seq_phase)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: return 1'b1;
      PH_WR_REST:                       return ~seq_shift[0];
      default:                          return 1'b0;
    endcase
  endfunction

  function automatic void open_slot();
    seq_ticks = '0;
    if (ticks_of(REG_SLOT_GAP, 1'b0) != '0) seq_phase = PH_GAP;
    else seq_phase = (seq_cmd == CMD_WRITE) ? PH_WR_LOW : PH_RD_LOW;
  endfunction

  function automatic logic close_slot();
    if (seq_bit == 3'd7) begin
      if (seq_cmd == CMD_READ) seq_last_read = seq_shift;
      seq_phase = PH_IDLE;
      seq_ticks = '0;
      seq_bit   = '0;
      return 1'b1;
    end
    seq_bit = seq_bit + 1'b1;
    open_slot();
    return 1'b0;
  endfunction

  function automatic bus_answer_t step_bus_sequencer(input logic is_cmd, input logic [1:0] code,
                                                     input logic [7:0] wdata, input logic line);
    bus_answer_t a;
    logic        drive;
    logic        fin;
    fin = 1'b0;
    if (is_cmd) begin
      // commands only start from idle, unknown codes fall through
      if (seq_phase == PH_IDLE && code inside {CMD_RESET, CMD_WRITE, CMD_READ}) begin
        seq_cmd   = cmd_e'(code);
        seq_ticks = '0;
        seq_bit   = '0;
        if (seq_cmd == CMD_RESET) begin
          seq_phase = PH_RST_LOW;
        end else begin
          seq_shift = (seq_cmd == CMD_WRITE) ? wdata : 8'h00;
          open_slot();
        end
      end
      drive = pulls_low();
    end else begin
      drive = pulls_low();
      case (seq_phase)
        PH_RST_LOW: begin
          if (count_hit(ticks_of(REG_RST_LOW, 1'b1))) seq_phase = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (count_hit(ticks_of(REG_PRES_WAIT, 1'b1))) seq_phase = PH_RST_SAMPLE;
        end
        PH_RST_SAMPLE: begin
          seq_ticks = '0;
          if (!line) begin
            seq_present = 1'b1;
            seq_phase   = PH_RST_HIGH;
          end else begin
            seq_present = 1'b0;
            seq_phase   = PH_IDLE;
            fin         = 1'b1;
          end
        end
        PH_RST_HIGH: begin
          if (line) begin
            seq_ticks = '0;
            if (ticks_of(REG_RST_REC, 1'b0) == '0) begin
              seq_phase = PH_IDLE;
              fin       = 1'b1;
            end else begin
              seq_phase = PH_RST_RECOVER;
            end
          end
        end
        PH_RST_RECOVER: begin
          if (count_hit(ticks_of(REG_RST_REC, 1'b0))) begin
            seq_phase = PH_IDLE;
            fin       = 1'b1;
          end
        end
        PH_GAP: begin
          if (count_hit(ticks_of(REG_SLOT_GAP, 1'b0)))
            seq_phase = (seq_cmd == CMD_WRITE) ? PH_WR_LOW : PH_RD_LOW;
        end
        PH_WR_LOW: begin
          if (count_hit(ticks_of(REG_WR_LOW, 1'b1))) seq_phase = PH_WR_REST;
        end
        PH_WR_REST: begin
          if (count_hit(ticks_of(REG_SLOT_REST, 1'b1))) begin
            seq_shift = seq_shift >> 1;
            fin       = close_slot();
          end
        end
        PH_RD_LOW: begin
          if (count_hit(ticks_of(REG_RD_LOW, 1'b1)))
            seq_phase = (ticks_of(REG_RD_SAMPLE, 1'b0) != '0) ? PH_RD_WAIT : PH_RD_REST;
        end
        PH_RD_WAIT: begin
          if (count_hit(ticks_of(REG_RD_SAMPLE, 1'b0))) seq_phase = PH_RD_REST;
        end
        PH_RD_REST: begin
          // bit is taken on the first tick of the slot remainder
          if (seq_ticks == '0) seq_shift = {line, seq_shift[7:1]};
          if (count_hit(ticks_of(REG_SLOT_REST, 1'b1))) fin = close_slot();
        end
        default: begin
          seq_phase = PH_IDLE;
          seq_ticks = '0;
        end
      endcase
    end
    a.pull_low  = drive;
    a.busy      = (seq_phase != PH_IDLE);
    a.done      = fin;
    a.read_byte = seq_last_read;
    a.present   = seq_present;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase     = PH_IDLE;
      seq_ticks     = '0;
      seq_bit       = '0;
      seq_shift     = '0;
      seq_cmd       = CMD_RESET;
      seq_present   = 1'b0;
      seq_last_read = '0;
      timing[REG_RST_LOW]   = 10'd500;
      timing[REG_PRES_WAIT] = 10'd60;
      timing[REG_RST_REC]   = 10'd420;
      timing[REG_SLOT_GAP]  = 10'd2;
      timing[REG_WR_LOW]    = 10'd10;
      timing[REG_SLOT_REST] = 10'd90;
      timing[REG_RD_LOW]    = 10'd2;
      timing[REG_RD_SAMPLE] = 10'd2;
      bus_answers_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.pull_low  = pull_low_i;
        seen.busy      = busy_res_i;
        seen.done      = done_res_i;
        seen.read_byte = read_data_i;
        seen.present   = presence_i;
        if (bus_answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result word at %0t: pull_low %0b busy %0b done %0b",
                     $realtime, seen.pull_low, seen.busy, seen.done);
        end else begin
          want = bus_answers_q.pop_front();
          if (want !== seen) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"mismatch at %0t (exp/got): pull_low %0b/%0b busy %0b/%0b",
                        " done %0b/%0b read_data %02h/%02h presence %0b/%0b"},
                       $realtime, want.pull_low, seen.pull_low, want.busy, seen.busy,
                       want.done, seen.done, want.read_byte, seen.read_byte,
                       want.present, seen.present);
          end
        end
      end
      if (psel && penable && pwrite && pready)
        timing[paddr[PAddrW-1:2]] = pwdata[RegW-1:0];
      if (in_valid_i && in_ready_i)
        bus_answers_q.push_back(step_bus_sequencer(kind_i, command_i, write_data_i, line_in_i));
    end
    mismatch_total_o = mismatches;
    answers_owed_o   = bus_answers_q.size();
  end

endmodule

// ===== bench/onewire_bus_master_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// onewire_bus_master_unit_test
// Drives reset, write and read operations into the 1-Wire bus master with
// line levels shaped to the programmed slot timings, plus stray and unknown
// commands, idle ticks and noise. Timing registers are reprogrammed between
// runs (defaults, all zero, random short). Both channel sides idle at random;
// the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module onewire_bus_master_unit_test;
  import owbm_pkg::*;

  localparam logic       KindTick      = 1'b0;
  localparam logic       KindCmd       = 1'b1;
  localparam logic [1:0] CmdUnknown    = 2'd3;
  localparam int         HoldOffCycles = 200;
  localparam int         SettleCycles  = 8;
  localparam int         RandomWords   = 500;

  typedef enum {TIMING_FLOOR, TIMING_CEIL, TIMING_SHORT, TIMING_MIXED} timing_mode_e;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              kind;
  logic [1:0]        command;
  logic [7:0]        write_data;
  logic              line_in;
  logic              out_valid;
  logic              out_ready;
  logic              pull_low;
  logic              busy_res;
  logic              done_res;
  logic [7:0]        read_data;
  logic              presence;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int              mismatch_total;
  int              answers_owed;
  logic [RegW-1:0] slot_cfg [NumRegs];
  bit              sender_calm;
  bit              drain_calm;
  bit              hold_req;
  int              stray_pct;
  int              words_sent;

  onewire_bus_master_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .command_i    (command),
    .write_data_i (write_data),
    .line_in_i    (line_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pull_low_o   (pull_low),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .read_data_o  (read_data),
    .presence_o   (presence),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  owbm_bus_checker bus_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .command_i        (command),
    .write_data_i     (write_data),
    .line_in_i        (line_in),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pull_low_i       (pull_low),
    .busy_res_i       (busy_res),
    .done_res_i       (done_res),
    .read_data_i      (read_data),
    .presence_i       (presence),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_total_o (mismatch_total),
    .answers_owed_o   (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #40_000_000;
    $display("onewire_bus_master_unit verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int at_least_one(input logic [RegW-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  initial begin : drain_side
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the input queue fills and stalls the sender
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!drain_calm) stall = gap_cycles();
      end
    end
  end

  task automatic send_word(input logic k, input logic [1:0] c, input logic [7:0] d,
                           input logic ln);
    int gap;
    gap = sender_calm ? 0 : gap_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    command    <= c;
    write_data <= d;
    line_in    <= ln;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_ticks(input int n, input int low_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_word(KindCmd, 2'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()));
      send_word(KindTick, 2'($urandom_range(0, 3)), 8'($urandom()),
                ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1);
    end
  endtask

  task automatic write_timing(input reg_idx_e idx, input logic [RegW-1:0] val);
    logic [PDataW-1:0] word;
    word           = $urandom();
    word[RegW-1:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_cfg[idx] = val;
  endtask

  task automatic program_timing(input timing_mode_e mode);
    logic [RegW-1:0] v;
    for (int i = 0; i < NumRegs; i++) begin
      case (mode)
        TIMING_FLOOR: v = '0;
        TIMING_CEIL:  v = '1;
        TIMING_SHORT: v = RegW'($urandom_range(0, 3));
        default:      v = RegW'($urandom_range(0, 12));
      endcase
      write_timing(reg_idx_e'(i), v);
    end
  endtask

  // stop offering words and let every owed result drain out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one operation: the command word, ticks shaped to the slot timings, then overrun ticks
  task automatic run_op(input cmd_e op, input logic [7:0] data, input int extra,
                        input int presence_pct);
    logic present;
    int   hold;
    send_word(KindCmd, op, data, 1'($urandom()));
    case (op)
      CMD_RESET: begin
        send_ticks(at_least_one(slot_cfg[REG_RST_LOW]) + at_least_one(slot_cfg[REG_PRES_WAIT]),
                   50);
        present = ($urandom_range(0, 99) < presence_pct);
        send_ticks(1, present ? 100 : 0);
        if (present) begin
          // device keeps the line low for a while, sometimes a long while
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
          send_ticks(hold, 100);
          send_ticks(1, 0);
          send_ticks(slot_cfg[REG_RST_REC], 50);
        end
      end
      CMD_WRITE: begin
        send_ticks(8 * (slot_cfg[REG_SLOT_GAP] + at_least_one(slot_cfg[REG_WR_LOW])
                        + at_least_one(slot_cfg[REG_SLOT_REST])), 50);
      end
      default: begin
        send_ticks(8 * (slot_cfg[REG_SLOT_GAP] + at_least_one(slot_cfg[REG_RD_LOW])
                        + slot_cfg[REG_RD_SAMPLE] + at_least_one(slot_cfg[REG_SLOT_REST])), 50);
      end
    endcase
    send_ticks(extra, 50);
  endtask

  initial begin : stimulus
    int          base;
    int          pick;
    int          dsel;
    bit          first_hold;
    cmd_e        op;
    logic [7:0]  data;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    kind        = KindTick;
    command     = CMD_RESET;
    write_data  = '0;
    line_in     = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_req    = 1'b0;
    stray_pct   = 0;
    words_sent  = 0;
    sender_calm = 1'b1;
    drain_calm  = 1'b1;
    for (int i = 0; i < NumRegs; i++) slot_cfg[i] = RegReset[i];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one reset with the timings straight out of reset, nobody answers
    run_op(CMD_RESET, 8'h00, 1, 0);
    settle();

    // directed: every register at zero, so floors apply and gaps vanish
    sender_calm = 1'b0;
    drain_calm  = 1'b0;
    program_timing(TIMING_FLOOR);
    send_word(KindTick, CMD_READ, 8'hFF, 1'b0);
    send_word(KindTick, CMD_WRITE, 8'h00, 1'b1);
    send_word(KindCmd, CmdUnknown, 8'hA5, 1'b0);
    send_word(KindCmd, CMD_RESET, 8'h00, 1'b1);
    send_word(KindCmd, CMD_WRITE, 8'h81, 1'b0);        // ignored while busy
    send_ticks(2, 50);
    send_ticks(1, 0);                                  // nobody answers
    run_op(CMD_RESET, 8'h00, 0, 100);                  // presence, no recovery
    run_op(CMD_WRITE, 8'hFF, 0, 0);
    settle();

    // random runs on short timings
    stray_pct  = 3;
    first_hold = 1'b1;
    base       = words_sent;
    while (words_sent - base < RandomWords) begin
      program_timing(($urandom_range(0, 3) == 0) ? TIMING_MIXED : TIMING_SHORT);
      sender_calm = ($urandom_range(0, 5) == 0);
      drain_calm  = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(3, 6)) begin
        if (first_hold || $urandom_range(0, 9) == 0) begin
          hold_req   = 1'b1;
          first_hold = 1'b0;
        end
        pick = $urandom_range(0, 99);
        dsel = $urandom_range(0, 99);
        data = (dsel < 15) ? 8'h00 : (dsel < 30) ? 8'hFF : 8'($urandom());
        if (pick < 10) begin
          repeat ($urandom_range(5, 15))
            send_word(1'($urandom()), 2'($urandom_range(0, 3)), 8'($urandom()),
                      1'($urandom()));
        end else begin
          op = (pick < 45) ? CMD_WRITE : (pick < 75) ? CMD_READ : CMD_RESET;
          run_op(op, data, $urandom_range(0, 3), 75);
        end
      end
      settle();
    end

    if (mismatch_total == 0 && answers_owed == 0)
      $display("onewire_bus_master_unit verification clean");
    else
      $display("onewire_bus_master_unit verification failed");
    $finish;
  end

endmodule
